@@ rtl/qvp_pkg.sv @@
// Shared constants, command codes and unit status type for the quad vertex projector.
// No dependencies; every other file in rtl/ imports this package.
package qvp_pkg;

    localparam int WORD_W      = 32;
    localparam int DIGIT_W     = 8;
    localparam int DIGITS      = WORD_W / DIGIT_W;
    localparam int TABLE_WORDS = 12;
    localparam int SCREEN_W    = 13;
    localparam int KEY_W       = 16;
    localparam int SUM_W       = 18;
    localparam int DEPTH_SHIFT = 6;
    localparam int SCREEN_LIMIT = 2048;

    localparam int HALF_SCREEN_WIDTH_DEF  = 160;
    localparam int HALF_SCREEN_HEIGHT_DEF = 112;
    localparam int DEPTH_LIMIT_DEF        = 50000;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    localparam logic [1:0] ROW_W = 2'd0;
    localparam logic [1:0] ROW_X = 2'd1;
    localparam logic [1:0] ROW_Y = 2'd2;

    localparam logic [1:0] TERM_LAST = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

@@ rtl/qvp_mul.sv @@
// Digit-serial multiplier keeping the low 32 bits of a*b, one 8-bit digit of b per cycle.
// Depends on qvp_pkg.
module qvp_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [qvp_pkg::WORD_W-1:0] a,
    input  logic [qvp_pkg::WORD_W-1:0] b,
    output qvp_pkg::unit_status_t      status,
    output logic [qvp_pkg::WORD_W-1:0] product
);
    import qvp_pkg::*;

    localparam int CNT_W = $clog2(DIGITS);

    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W+DIGIT_W-1:0] partial;

    // One digit partial product, truncated to the word
    assign partial = a_reg * b_reg[DIGIT_W-1:0];

    // Load on start, then shift one digit per cycle
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + partial[WORD_W-1:0];
            a_next   = a_reg << DIGIT_W;
            b_next   = b_reg >> DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule

@@ rtl/qvp_div.sv @@
// Bit-serial restoring divider: signed numerator over positive divisor, truncating.
// Depends on qvp_pkg.
module qvp_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [qvp_pkg::WORD_W-1:0] num,
    input  logic [qvp_pkg::WORD_W-1:0] den,
    output qvp_pkg::unit_status_t      status,
    output logic [qvp_pkg::WORD_W-1:0] quotient
);
    import qvp_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] q_reg, q_next;
    logic [WORD_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, q_reg[WORD_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // Take the magnitude, then one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            neg_next  = num[WORD_W-1];
            q_next    = num[WORD_W-1] ? (~num + 1'b1) : num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!rem_sub[WORD_W])
            begin
                rem_next = rem_sub[WORD_W-1:0];
                q_next   = {q_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[WORD_W-1:0];
                q_next   = {q_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = neg_reg ? (~q_reg + 1'b1) : q_reg;

endmodule

@@ rtl/quad_vertex_projector.sv @@
// Top level of the quad vertex projector: matrix store, sequencer, quad tracking.
// Depends on qvp_pkg, qvp_mul and qvp_div.
//
// Usage: one input channel (in_valid/in_ready) carries either a matrix load
// (cmd = load, coef_index, coef_value) or a vertex (cmd = vertex, vertex_x/y/z).
// A load transaction writes one of twelve matrix words and gives no result;
// an index above eleven is dropped. A vertex transaction gives one result
// transaction on the output channel (out_valid/out_ready): screen position,
// vertex pass flag and, on every fourth vertex, the quad flags and depth key.
// A vertex takes eleven 32-bit products on one digit-serial multiplier at 8
// bits per cycle and two bit-serial dividers run side by side. A vertex with
// non-positive w skips the projection and the divides. One vertex is worked
// on at a time.
// The result sits in an output register; a new item is accepted while it
// waits, and the finished next result holds until out_ready frees the
// register. Reset clears the matrix, the quad position, depth sum and
// failure flag, and empties the output register.
module quad_vertex_projector #(
    parameter int HALF_SCREEN_WIDTH  = qvp_pkg::HALF_SCREEN_WIDTH_DEF,
    parameter int HALF_SCREEN_HEIGHT = qvp_pkg::HALF_SCREEN_HEIGHT_DEF,
    parameter int DEPTH_LIMIT        = qvp_pkg::DEPTH_LIMIT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic [3:0]                        coef_index,
    input  logic signed [qvp_pkg::WORD_W-1:0] coef_value,
    input  logic signed [qvp_pkg::WORD_W-1:0] vertex_x,
    input  logic signed [qvp_pkg::WORD_W-1:0] vertex_y,
    input  logic signed [qvp_pkg::WORD_W-1:0] vertex_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [qvp_pkg::SCREEN_W-1:0] screen_x,
    output logic signed [qvp_pkg::SCREEN_W-1:0] screen_y,
    output logic                              vertex_ok,
    output logic                              quad_done,
    output logic                              quad_ok,
    output logic [qvp_pkg::KEY_W-1:0]         depth_key
);
    import qvp_pkg::*;

    localparam logic [WORD_W-1:0] SCALE_X = WORD_W'(HALF_SCREEN_WIDTH);
    localparam logic [WORD_W-1:0] SCALE_Y = WORD_W'(0 - HALF_SCREEN_HEIGHT);
    localparam int DEPTH_W = WORD_W - DEPTH_SHIFT;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(DEPTH_LIMIT);
    localparam logic signed [WORD_W-1:0] LIM_HI = WORD_W'(SCREEN_LIMIT);
    localparam logic signed [WORD_W-1:0] LIM_LO = WORD_W'(0 - SCREEN_LIMIT);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_SCALE = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [WORD_W-1:0] coef_reg [TABLE_WORDS];
    logic [WORD_W-1:0] vx_reg, vy_reg, vz_reg;
    logic [1:0]        row_reg, row_next;
    logic [1:0]        term_reg, term_next;
    logic              launch_reg, launch_next;
    logic              sel_reg, sel_next;
    logic              div_go_reg, div_go_next;
    logic              wpos_reg, wpos_next;
    logic [WORD_W-1:0] sum_reg, sum_next;
    logic [WORD_W-1:0] w_reg, w_next;
    logic [WORD_W-1:0] rx_reg, rx_next;
    logic [WORD_W-1:0] ry_reg, ry_next;
    logic [WORD_W-1:0] nx_reg, nx_next;
    logic [WORD_W-1:0] ny_reg, ny_next;

    logic [1:0]        pos_reg;
    logic [SUM_W-1:0]  dsum_reg;
    logic              rej_reg;

    logic                      out_valid_reg;
    logic signed [SCREEN_W-1:0] sx_reg, sy_reg;
    logic                      vok_reg, qdone_reg, qok_reg;
    logic [KEY_W-1:0]          key_reg;

    logic [3:0]        rd_idx;
    logic [WORD_W-1:0] vsel;
    logic              mul_start;
    logic [WORD_W-1:0] mul_a, mul_b, mul_p;
    unit_status_t      mul_st, divx_st, divy_st;
    logic [WORD_W-1:0] qx, qy;
    logic [WORD_W-1:0] row_val;
    logic              accept, load_wr, out_free, finish;
    logic [DEPTH_W-1:0] depth;
    logic              ok;
    logic [SUM_W-1:0]  dsum_add;

    assign accept   = in_valid && in_ready;
    assign load_wr  = accept && (cmd == CMD_LOAD) && (coef_index < 4'(TABLE_WORDS));
    assign out_free = !out_valid_reg || out_ready;
    assign finish   = (state_reg == S_OUT) && out_free;
    assign in_ready = (state_reg == S_IDLE);

    // Select the column term and vertex component for the current product
    assign rd_idx  = {row_reg, term_reg} + 4'd1;
    assign row_val = sum_reg + mul_p;

    always_comb
    begin
        case (term_reg)
            2'd0:    vsel = vx_reg;
            2'd1:    vsel = vy_reg;
            default: vsel = vz_reg;
        endcase
    end

    assign mul_start = launch_reg && ((state_reg == S_MUL) || (state_reg == S_SCALE));
    assign mul_a = (state_reg == S_SCALE) ? (sel_reg ? ry_reg : rx_reg) : coef_reg[rd_idx];
    assign mul_b = (state_reg == S_SCALE) ? (sel_reg ? SCALE_Y : SCALE_X) : vsel;

    qvp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .status  (mul_st),
        .product (mul_p)
    );

    qvp_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .num      (nx_reg),
        .den      (w_reg),
        .status   (divx_st),
        .quotient (qx)
    );

    qvp_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .num      (ny_reg),
        .den      (w_reg),
        .status   (divy_st),
        .quotient (qy)
    );

    // Sequence row sums, scale products and divides
    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        term_next   = term_reg;
        launch_next = 1'b0;
        sel_next    = sel_reg;
        div_go_next = 1'b0;
        wpos_next   = wpos_reg;
        sum_next    = sum_reg;
        w_next      = w_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == CMD_VERTEX))
                begin
                    row_next    = ROW_W;
                    term_next   = 2'd0;
                    sum_next    = coef_reg[0];
                    launch_next = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_st.done)
                begin
                    sum_next = row_val;
                    if (term_reg == TERM_LAST)
                    begin
                        term_next = 2'd0;
                        if (row_reg == ROW_W)
                        begin
                            w_next    = row_val;
                            wpos_next = !row_val[WORD_W-1] && (row_val != '0);
                            if (!row_val[WORD_W-1] && (row_val != '0))
                            begin
                                row_next    = ROW_X;
                                sum_next    = coef_reg[4];
                                launch_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end
                        else if (row_reg == ROW_X)
                        begin
                            rx_next     = row_val;
                            row_next    = ROW_Y;
                            sum_next    = coef_reg[8];
                            launch_next = 1'b1;
                        end
                        else
                        begin
                            ry_next     = row_val;
                            sel_next    = 1'b0;
                            launch_next = 1'b1;
                            state_next  = S_SCALE;
                        end
                    end
                    else
                    begin
                        term_next   = term_reg + 2'd1;
                        launch_next = 1'b1;
                    end
                end
            end
            S_SCALE:
            begin
                if (mul_st.done)
                begin
                    if (!sel_reg)
                    begin
                        nx_next     = mul_p;
                        sel_next    = 1'b1;
                        launch_next = 1'b1;
                    end
                    else
                    begin
                        ny_next     = mul_p;
                        div_go_next = 1'b1;
                        state_next  = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (divx_st.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Range checks on the finished vertex
    assign depth = w_reg[WORD_W-1:DEPTH_SHIFT];
    assign ok = wpos_reg &&
                ($signed(qx) >= LIM_LO) && ($signed(qx) <= LIM_HI) &&
                ($signed(qy) >= LIM_LO) && ($signed(qy) <= LIM_HI) &&
                (depth <= DEPTH_MAX);
    assign dsum_add = dsum_reg + depth[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            div_go_reg    <= 1'b0;
            pos_reg       <= '0;
            dsum_reg      <= '0;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_WORDS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            div_go_reg <= div_go_next;
            // Store a matrix word
            if (load_wr)
            begin
                coef_reg[coef_index] <= coef_value;
            end
            // Close the vertex and advance the quad
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                if (pos_reg == 2'd3)
                begin
                    pos_reg  <= '0;
                    dsum_reg <= '0;
                    rej_reg  <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_reg + 2'd1;
                    if (ok)
                    begin
                        dsum_reg <= dsum_add;
                    end
                    else
                    begin
                        rej_reg <= 1'b1;
                    end
                end
            end
            // Drop the result once taken
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold datapath and result payload
    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        term_reg <= term_next;
        sel_reg  <= sel_next;
        wpos_reg <= wpos_next;
        sum_reg  <= sum_next;
        w_reg    <= w_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        if (accept)
        begin
            vx_reg <= vertex_x;
            vy_reg <= vertex_y;
            vz_reg <= vertex_z;
        end
        if (finish)
        begin
            sx_reg    <= ok ? qx[SCREEN_W-1:0] : '0;
            sy_reg    <= ok ? qy[SCREEN_W-1:0] : '0;
            vok_reg   <= ok;
            qdone_reg <= (pos_reg == 2'd3);
            qok_reg   <= (pos_reg == 2'd3) && !rej_reg && ok;
            key_reg   <= ((pos_reg == 2'd3) && !rej_reg && ok) ?
                         (KEY_W'(16'hFFFF) - dsum_add[SUM_W-1:2]) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;
    assign vertex_ok = vok_reg;
    assign quad_done = qdone_reg;
    assign quad_ok   = qok_reg;
    assign depth_key = key_reg;

`ifndef ASSERT_OFF
    a_div_no_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> !mul_st.busy)
        else $error("multiplier busy during divide");
    a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
        divx_st.done == divy_st.done)
        else $error("dividers out of step");
    a_qok_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && quad_ok) |-> (quad_done && vertex_ok))
        else $error("quad pass without quad close");
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !vertex_ok) |-> ((screen_x == '0) && (screen_y == '0)))
        else $error("rejected vertex with screen position");
`endif

endmodule
